>>> src/sva_pkg.sv
// Package for the sampler voice allocator: voice states, event kinds,
// result codes and sequencer states. No dependencies.
package sva_pkg;

    typedef enum logic [1:0] {
        VS_FREE = 2'd0,
        VS_PLAY = 2'd1,
        VS_STOP = 2'd2
    } t_vstat;

    localparam logic [2:0] KIND_NOTE_ON  = 3'd0;
    localparam logic [2:0] KIND_NOTE_OFF = 3'd1;
    localparam logic [2:0] KIND_RECLAIM  = 3'd2;
    localparam logic [2:0] KIND_ENDED    = 3'd3;
    localparam logic [2:0] KIND_ALL_OFF  = 3'd4;

    localparam logic [1:0] RES_RETIRED = 2'd0;
    localparam logic [1:0] RES_STARTED = 2'd1;
    localparam logic [1:0] RES_DROPPED = 2'd2;

    typedef enum logic [3:0] {
        S_IDLE,
        S_NOTEOFF,
        S_RETIRE,
        S_CHOKE,
        S_LAYER,
        S_ALLOC,
        S_DECIDE,
        S_ALLOFF
    } t_state;

endpackage

>>> src/sampler_voice_allocator_unit.sv
// Sampler voice allocator top level: voice pool, scan sequencer, output stage.
// Depends on sva_pkg.
//
// Each event is handled one at a time. A note-on makes one pass over the
// voice pool to retire stopping voices, one pass to choke its group, up to
// LAYERS tries to find a loaded layer, and then one pass over the pool plus
// a decision state per allocation attempt (one attempt plus one per stolen
// voice); every result beat waits until the output takes it. A single scan
// pointer walks the voice pool. Note-off, reclaim and all-notes-off take one
// pass over the pool; voice-ended and ignored events are handled in the
// accepting cycle.
module sampler_voice_allocator_unit #(
    parameter int MAX_VOICES = 16,
    parameter int SLOT_COUNT = 16,
    parameter int LAYERS     = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // kind[2:0], note[6:3], velocity[13:7], slot_group[21:14],
    // layer_count[24:22], layer_present[28:25], slot_loop[29], voice_index[33:30]
    input  logic [39:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // event_res[1:0], out_note[5:2], out_layer[7:6], out_voice[11:8]
    output logic [15:0] m_axis_tdata,
    output logic        m_axis_tlast,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [4:0]  i_cfg_data
);

    localparam int VW = (MAX_VOICES > 1) ? $clog2(MAX_VOICES) : 1;
    localparam int CW = $clog2(MAX_VOICES + 1);
    localparam int LW = (LAYERS > 1) ? $clog2(LAYERS) : 1;
    localparam int SW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

    // input fields
    logic [2:0] f_kind;
    logic [3:0] f_note;
    logic [6:0] f_vel;
    logic [7:0] f_grp;
    logic [2:0] f_cnt;
    logic [3:0] f_present;
    logic       f_loop;
    logic [3:0] f_vidx;
    assign f_kind    = s_axis_tdata[2:0];
    assign f_note    = s_axis_tdata[6:3];
    assign f_vel     = s_axis_tdata[13:7];
    assign f_grp     = s_axis_tdata[21:14];
    assign f_cnt     = s_axis_tdata[24:22];
    assign f_present = s_axis_tdata[28:25];
    assign f_loop    = s_axis_tdata[29];
    assign f_vidx    = s_axis_tdata[33:30];

    // voice pool
    sva_pkg::t_vstat r_stat [MAX_VOICES];
    logic [3:0]      r_vnote [MAX_VOICES];
    logic [1:0]      r_vlayer [MAX_VOICES];
    logic [7:0]      r_vgrp [MAX_VOICES];
    logic            r_vloop [MAX_VOICES];
    logic [31:0]     r_vage [MAX_VOICES];
    logic [LW-1:0]   r_next_layer [SLOT_COUNT];
    logic [31:0]     r_age_counter;
    logic [31:0]     r_dropped;
    logic [4:0]      r_max_poly;

    // latched event
    logic [3:0]    r_note;
    logic [7:0]    r_grp;
    logic [3:0]    r_cnt;
    logic [3:0]    r_present;
    logic          r_loop;
    logic          r_haslayer;

    // sequencer
    sva_pkg::t_state r_state, n_state;
    logic [VW:0]   r_idx;
    logic [LW:0]   r_tries;
    logic [LW-1:0] r_layer;
    logic [CW-1:0] r_playing;
    logic          r_free_ok;
    logic [VW-1:0] r_free_i;
    logic          r_old_ok;
    logic [VW-1:0] r_old_i;
    logic [31:0]   r_old_age;
    sva_pkg::t_state r_ret_state;

    // output register
    logic        r_ovalid;
    logic [15:0] r_odata;
    logic        r_olast;

    logic [VW-1:0] cur;
    logic          scan_end;
    logic [CW-1:0] cap;
    logic          out_free;
    logic          in_fire;
    logic [4:0]    mp_clamp;
    logic [3:0]    lay_mask;
    logic          out_load;

    assign cur      = r_idx[VW-1:0];
    assign scan_end = (r_idx == (VW+1)'(MAX_VOICES - 1));
    assign out_free = !r_ovalid || m_axis_tready;
    assign in_fire  = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (r_state == sva_pkg::S_IDLE);
    assign o_cfg_ready   = (r_state == sva_pkg::S_IDLE) && !r_ovalid;
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_odata;
    assign m_axis_tlast  = r_olast;

    // clamp polyphony cap to 1..MAX_VOICES
    always_comb begin
        mp_clamp = (r_max_poly == 5'd0) ? 5'd1 : r_max_poly;
        if (32'(mp_clamp) > MAX_VOICES) cap = CW'(MAX_VOICES);
        else cap = CW'(mp_clamp);
    end

    // layer positions in use for the incoming event, count clamped to LAYERS
    always_comb begin
        lay_mask = '0;
        for (int k = 0; k < 4; k++) begin
            if (k < LAYERS && 3'(k) < f_cnt) lay_mask[k] = 1'b1;
        end
    end

    // is there any stopping voice left after cur (for last flag of reclaim)
    logic stop_after, nz_after;
    always_comb begin
        stop_after = 1'b0;
        nz_after   = 1'b0;
        for (int k = 0; k < MAX_VOICES; k++) begin
            if (k > int'(cur) && r_stat[k] == sva_pkg::VS_STOP) stop_after = 1'b1;
            if (k > int'(cur) && r_stat[k] != sva_pkg::VS_FREE) nz_after = 1'b1;
        end
    end

    // a result beat enters the output register this cycle
    always_comb begin
        out_load = 1'b0;
        if (out_free) begin
            if (r_state == sva_pkg::S_RETIRE && r_stat[cur] == sva_pkg::VS_STOP)
                out_load = 1'b1;
            if (r_state == sva_pkg::S_ALLOFF && r_stat[cur] != sva_pkg::VS_FREE)
                out_load = 1'b1;
            if (r_state == sva_pkg::S_DECIDE)
                out_load = 1'b1;
        end
    end

    // next-state logic
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            sva_pkg::S_IDLE: begin
                if (in_fire) begin
                    if ((f_kind == sva_pkg::KIND_NOTE_ON || f_kind == sva_pkg::KIND_NOTE_OFF)
                        && 32'(f_note) < SLOT_COUNT) begin
                        if (f_kind == sva_pkg::KIND_NOTE_OFF || f_vel == 7'd0)
                            n_state = sva_pkg::S_NOTEOFF;
                        else if (f_cnt != 3'd0)
                            n_state = sva_pkg::S_RETIRE;
                    end else if (f_kind == sva_pkg::KIND_RECLAIM) begin
                        n_state = sva_pkg::S_RETIRE;
                    end else if (f_kind == sva_pkg::KIND_ALL_OFF) begin
                        n_state = sva_pkg::S_ALLOFF;
                    end
                end
            end
            sva_pkg::S_NOTEOFF: if (scan_end) n_state = sva_pkg::S_IDLE;
            sva_pkg::S_RETIRE, sva_pkg::S_ALLOFF: begin
                if (!out_free) n_state = r_state;
                else if (scan_end) n_state = r_ret_state;
            end
            sva_pkg::S_CHOKE: if (scan_end) n_state = sva_pkg::S_LAYER;
            sva_pkg::S_LAYER: begin
                if (r_present[r_layer]) n_state = sva_pkg::S_ALLOC;
                else if (r_tries + 1'b1 >= r_cnt[LW:0]) n_state = sva_pkg::S_IDLE;
            end
            sva_pkg::S_ALLOC: if (scan_end) n_state = sva_pkg::S_DECIDE;
            sva_pkg::S_DECIDE: begin
                if (out_free) begin
                    if ((r_playing < cap && r_free_ok) || !r_old_ok)
                        n_state = sva_pkg::S_IDLE;
                    else n_state = sva_pkg::S_ALLOC;
                end
            end
            default: n_state = sva_pkg::S_IDLE;
        endcase
    end

    // state, pool and output updates
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= sva_pkg::S_IDLE;
            r_ovalid      <= 1'b0;
            r_age_counter <= '0;
            r_dropped     <= '0;
            r_max_poly    <= 5'd16;
            r_idx         <= '0;
            r_ret_state   <= sva_pkg::S_IDLE;
            for (int k = 0; k < MAX_VOICES; k++) begin
                r_stat[k]   <= sva_pkg::VS_FREE;
                r_vnote[k]  <= '0;
                r_vlayer[k] <= '0;
                r_vgrp[k]   <= '0;
                r_vloop[k]  <= 1'b0;
                r_vage[k]   <= '0;
            end
            for (int k = 0; k < SLOT_COUNT; k++) r_next_layer[k] <= '0;
        end else begin
            r_state <= n_state;
            // load a new beat or drop the one just taken
            if (out_load) r_ovalid <= 1'b1;
            else if (m_axis_tready) r_ovalid <= 1'b0;
            if (i_cfg_valid && o_cfg_ready) r_max_poly <= i_cfg_data;

            unique case (r_state)
                sva_pkg::S_IDLE: begin
                    r_idx <= '0;
                    if (in_fire) begin
                        r_note    <= f_note;
                        r_grp     <= f_grp;
                        r_cnt     <= (f_cnt > 3'(LAYERS)) ? 4'(LAYERS) : {1'b0, f_cnt};
                        r_present <= f_present;
                        r_loop    <= f_loop;
                        r_haslayer <= |(f_present & lay_mask);
                        r_ret_state <= (f_kind == sva_pkg::KIND_NOTE_ON)
                                       ? sva_pkg::S_CHOKE : sva_pkg::S_IDLE;
                        if (f_kind == sva_pkg::KIND_ENDED && 32'(f_vidx) < MAX_VOICES
                            && r_stat[VW'(f_vidx)] == sva_pkg::VS_PLAY)
                            r_stat[VW'(f_vidx)] <= sva_pkg::VS_STOP;
                    end
                end
                sva_pkg::S_NOTEOFF: begin
                    if (r_stat[cur] == sva_pkg::VS_PLAY && r_vnote[cur] == r_note
                        && r_vloop[cur])
                        r_stat[cur] <= sva_pkg::VS_STOP;
                    r_idx <= scan_end ? '0 : r_idx + 1'b1;
                end
                sva_pkg::S_RETIRE, sva_pkg::S_ALLOFF: begin
                    if (out_free) begin
                        if ((r_state == sva_pkg::S_RETIRE && r_stat[cur] == sva_pkg::VS_STOP)
                            || (r_state == sva_pkg::S_ALLOFF
                                && r_stat[cur] != sva_pkg::VS_FREE)) begin
                            r_stat[cur] <= sva_pkg::VS_FREE;
                            r_odata     <= {4'd0, 4'(cur), r_vlayer[cur], r_vnote[cur],
                                            sva_pkg::RES_RETIRED};
                            // last only when nothing more follows in this event
                            r_olast     <= (r_state == sva_pkg::S_ALLOFF) ? !nz_after
                                         : ((r_ret_state == sva_pkg::S_IDLE || !r_haslayer)
                                            && !stop_after);
                        end
                        r_idx <= scan_end ? '0 : r_idx + 1'b1;
                    end
                    r_tries <= '0;
                    r_layer <= '0;
                end
                sva_pkg::S_CHOKE: begin
                    if (r_grp != 8'd0 && r_stat[cur] == sva_pkg::VS_PLAY
                        && r_vgrp[cur] == r_grp)
                        r_stat[cur] <= sva_pkg::VS_STOP;
                    r_idx <= scan_end ? '0 : r_idx + 1'b1;
                    r_tries <= '0;
                    r_layer <= ({1'b0, r_next_layer[r_note[SW-1:0]]} >= r_cnt[LW:0])
                               ? '0 : r_next_layer[r_note[SW-1:0]];
                end
                sva_pkg::S_LAYER: begin
                    if (r_present[r_layer]) begin
                        r_next_layer[r_note[SW-1:0]] <=
                            ({1'b0, r_layer} + 1'b1 >= r_cnt[LW:0]) ? '0 : r_layer + 1'b1;
                    end else begin
                        r_tries <= r_tries + 1'b1;
                        r_layer <= ({1'b0, r_layer} + 1'b1 >= r_cnt[LW:0]) ? '0 : r_layer + 1'b1;
                    end
                    r_idx <= '0; r_playing <= '0; r_free_ok <= 1'b0; r_old_ok <= 1'b0;
                end
                sva_pkg::S_ALLOC: begin
                    if (r_stat[cur] == sva_pkg::VS_FREE && !r_free_ok) begin
                        r_free_ok <= 1'b1; r_free_i <= cur;
                    end else if (r_stat[cur] == sva_pkg::VS_PLAY) begin
                        r_playing <= r_playing + 1'b1;
                        if (!r_old_ok || r_vage[cur] < r_old_age) begin
                            r_old_ok <= 1'b1; r_old_i <= cur; r_old_age <= r_vage[cur];
                        end
                    end
                    r_idx <= scan_end ? '0 : r_idx + 1'b1;
                end
                sva_pkg::S_DECIDE: begin
                    // hold the scan results until the output register is free
                    if (out_free) begin
                        if (r_playing < cap && r_free_ok) begin
                            r_stat[r_free_i]   <= sva_pkg::VS_PLAY;
                            r_vnote[r_free_i]  <= r_note;
                            r_vlayer[r_free_i] <= 2'(r_layer);
                            r_vgrp[r_free_i]   <= r_grp;
                            r_vloop[r_free_i]  <= r_loop;
                            r_vage[r_free_i]   <= r_age_counter + 1'b1;
                            r_age_counter      <= r_age_counter + 1'b1;
                            r_odata <= {4'd0, 4'(r_free_i), 2'(r_layer), r_note,
                                        sva_pkg::RES_STARTED};
                            r_olast <= 1'b1;
                        end else if (!r_old_ok) begin
                            r_dropped <= r_dropped + 1'b1;
                            r_odata <= {4'd0, 4'd0, 2'd0, r_note, sva_pkg::RES_DROPPED};
                            r_olast <= 1'b1;
                        end else begin
                            r_stat[r_old_i] <= sva_pkg::VS_FREE;
                            r_odata <= {4'd0, 4'(r_old_i), r_vlayer[r_old_i],
                                        r_vnote[r_old_i], sva_pkg::RES_RETIRED};
                            r_olast <= 1'b0;
                        end
                        r_idx <= '0; r_playing <= '0; r_free_ok <= 1'b0; r_old_ok <= 1'b0;
                    end
                end
                default: ;
            endcase
        end
    end

`ifndef NO_ASSERTIONS
    a_busy_no_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != sva_pkg::S_IDLE) |-> !s_axis_tready) else $error("ready while busy");
    a_hold_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> $stable(m_axis_tdata))
        else $error("result changed under stall");
    a_cfg_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cfg_ready |-> (r_state == sva_pkg::S_IDLE)) else $error("cfg while busy");
    a_playing_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == sva_pkg::S_DECIDE) |-> (r_playing <= CW'(MAX_VOICES)))
        else $error("playing count overflow");
`endif

endmodule

>>> verif/tb_sampler_voice_allocator_unit.sv
// Testbench for sampler_voice_allocator_unit: random and directed voice events,
// results checked beat by beat against an in-bench model of the voice pool.
// Depends on sva_pkg and the RTL of the block.
module tb_sampler_voice_allocator_unit;

    localparam int NV = 16;
    localparam int NS = 16;
    localparam int NL = 4;

    typedef struct packed {
        logic [2:0] kind;
        logic [3:0] note;
        logic [6:0] vel;
        logic [7:0] grp;
        logic [2:0] cnt;
        logic [3:0] present;
        logic       loop_f;
        logic [3:0] vidx;
    } t_event;

    typedef struct packed {
        logic [1:0] res;
        logic [3:0] note;
        logic [1:0] layer;
        logic [3:0] voice;
        logic       last;
    } t_beat;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [15:0] m_axis_tdata;
    logic        m_axis_tlast;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [4:0]  i_cfg_data;

    sampler_voice_allocator_unit u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data)
    );

    // Voice pool mirror
    sva_pkg::t_vstat pool_stat [NV];
    logic [3:0]  pool_note [NV];
    logic [1:0]  pool_layer[NV];
    logic [7:0]  pool_grp  [NV];
    logic        pool_loop [NV];
    logic [31:0] pool_age  [NV];
    logic [1:0]  rr_layer  [NS];
    logic [31:0] age_now;
    logic [4:0]  poly_cap;

    t_event pending_events[$];
    t_beat  expected_beats[$];
    int     mismatches = 0;
    bit     hold_sender = 0;
    bit     calm_phase = 0;

    function automatic t_beat mk_beat(logic [1:0] r, logic [3:0] n, logic [1:0] l,
                                      logic [3:0] v);
        t_beat b;
        b.res = r; b.note = n; b.layer = l; b.voice = v; b.last = 1'b0;
        return b;
    endfunction

    function automatic void retire_voice(int i, ref t_beat bq[$]);
        if (pool_stat[i] != sva_pkg::VS_FREE) begin
            pool_stat[i] = sva_pkg::VS_FREE;
            bq = {bq, mk_beat(sva_pkg::RES_RETIRED, pool_note[i], pool_layer[i], 4'(i))};
        end
    endfunction

    // Work out the beats one event causes and advance the pool mirror
    task automatic allocate_event(input t_event e);
        t_beat bq[$];
        int    cnt, layer, tries, cap, chosen, free_i, old_i, playing;
        logic [31:0] old_age;
        if (e.kind == sva_pkg::KIND_NOTE_ON || e.kind == sva_pkg::KIND_NOTE_OFF) begin
            if (e.kind == sva_pkg::KIND_NOTE_OFF || e.vel == 0) begin
                for (int i = 0; i < NV; i++)
                    if (pool_stat[i] == sva_pkg::VS_PLAY && pool_note[i] == e.note
                        && pool_loop[i])
                        pool_stat[i] = sva_pkg::VS_STOP;
            end else if (e.cnt != 0) begin
                cnt = (e.cnt > NL) ? NL : e.cnt;
                for (int i = 0; i < NV; i++)
                    if (pool_stat[i] == sva_pkg::VS_STOP) retire_voice(i, bq);
                if (e.grp != 0)
                    for (int i = 0; i < NV; i++)
                        if (pool_stat[i] == sva_pkg::VS_PLAY && pool_grp[i] == e.grp)
                            pool_stat[i] = sva_pkg::VS_STOP;
                layer = rr_layer[e.note];
                if (layer >= cnt) layer = 0;
                for (tries = 0; tries < cnt && !e.present[layer]; tries++)
                    layer = (layer + 1) % cnt;
                if (e.present[layer]) begin
                    rr_layer[e.note] = 2'((layer + 1) % cnt);
                    cap = poly_cap;
                    if (cap < 1) cap = 1;
                    if (cap > NV) cap = NV;
                    chosen = -1;
                    forever begin
                        free_i = -1; old_i = -1; playing = 0; old_age = 0;
                        for (int i = 0; i < NV; i++) begin
                            if (pool_stat[i] == sva_pkg::VS_FREE) begin
                                if (free_i < 0) free_i = i;
                            end else if (pool_stat[i] == sva_pkg::VS_PLAY) begin
                                playing++;
                                if (old_i < 0 || pool_age[i] < old_age) begin
                                    old_age = pool_age[i];
                                    old_i = i;
                                end
                            end
                        end
                        if (playing < cap && free_i >= 0) begin
                            chosen = free_i;
                            break;
                        end
                        if (old_i < 0) break;
                        retire_voice(old_i, bq);
                    end
                    if (chosen < 0) begin
                        bq = {bq, mk_beat(sva_pkg::RES_DROPPED, e.note, 2'd0, 4'd0)};
                    end else begin
                        pool_note[chosen]  = e.note;
                        pool_layer[chosen] = 2'(layer);
                        pool_grp[chosen]   = e.grp;
                        pool_loop[chosen]  = e.loop_f;
                        age_now++;
                        pool_age[chosen]   = age_now;
                        pool_stat[chosen]  = sva_pkg::VS_PLAY;
                        bq = {bq, mk_beat(sva_pkg::RES_STARTED, e.note, 2'(layer),
                                          4'(chosen))};
                    end
                end
            end
        end else if (e.kind == sva_pkg::KIND_RECLAIM) begin
            for (int i = 0; i < NV; i++)
                if (pool_stat[i] == sva_pkg::VS_STOP) retire_voice(i, bq);
        end else if (e.kind == sva_pkg::KIND_ENDED) begin
            if (pool_stat[e.vidx] == sva_pkg::VS_PLAY) pool_stat[e.vidx] = sva_pkg::VS_STOP;
        end else if (e.kind == sva_pkg::KIND_ALL_OFF) begin
            for (int i = 0; i < NV; i++) retire_voice(i, bq);
        end
        if (bq.size() > 0) bq[bq.size() - 1].last = 1'b1;
        expected_beats = {expected_beats, bq};
    endtask

    function automatic t_event rand_event();
        t_event e;
        int     r;
        e = t_event'({$urandom, $urandom});
        r = $urandom_range(0, 99);
        if (r < 55)      e.kind = sva_pkg::KIND_NOTE_ON;
        else if (r < 68) e.kind = sva_pkg::KIND_NOTE_OFF;
        else if (r < 78) e.kind = sva_pkg::KIND_RECLAIM;
        else if (r < 92) e.kind = sva_pkg::KIND_ENDED;
        else if (r < 96) e.kind = sva_pkg::KIND_ALL_OFF;
        else             e.kind = 3'($urandom_range(5, 7));
        // mostly well-formed events with a small group set so chokes occur
        if ($urandom_range(0, 9) < 8) begin
            e.cnt = 3'($urandom_range(1, 4));
            if ($urandom_range(0, 3) != 0) e.grp = 8'($urandom_range(0, 3));
            if ($urandom_range(0, 9) == 0) e.vel = 7'd0;
        end
        return e;
    endfunction

    // Queue one directed event
    function automatic void add_event(logic [2:0] k, logic [3:0] n, logic [6:0] v,
                                      logic [7:0] g, logic [2:0] c, logic [3:0] p,
                                      logic lp, logic [3:0] vi);
        t_event e;
        e.kind = k; e.note = n; e.vel = v; e.grp = g;
        e.cnt = c; e.present = p; e.loop_f = lp; e.vidx = vi;
        pending_events = {pending_events, e};
    endfunction

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Sender
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
        end else if (s_axis_tvalid && !s_axis_tready) begin
            // hold the beat
        end else if (pending_events.size() > 0 && !hold_sender &&
                     (calm_phase || $urandom_range(0, 99) >= 18)) begin
            t_event e;
            e = pending_events.pop_front();
            allocate_event(e);
            s_axis_tvalid <= 1'b1;
            s_axis_tdata  <= {6'd0, e.vidx, e.loop_f, e.present, e.cnt, e.grp,
                              e.vel, e.note, e.kind};
        end else begin
            s_axis_tvalid <= 1'b0;
        end
    end

    // Receiver: random stall and compare
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                t_beat got;
                t_beat want;
                got = {m_axis_tdata[1:0], m_axis_tdata[5:2], m_axis_tdata[7:6],
                       m_axis_tdata[11:8], m_axis_tlast};
                if (expected_beats.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result beat %h", got);
                end else begin
                    want = expected_beats.pop_front();
                    if (got !== want) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display("mismatch expected res %0d note %0d layer %0d voice %0d last %0d",
                                     want.res, want.note, want.layer, want.voice, want.last);
                            $display("         actual   res %0d note %0d layer %0d voice %0d last %0d",
                                     got.res, got.note, got.layer, got.voice, got.last);
                        end
                    end
                end
            end
            m_axis_tready <= calm_phase || ($urandom_range(0, 99) >= 18);
        end
    end

    task automatic write_cap(input logic [4:0] v);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        poly_cap = v;
    endtask

    task automatic drain();
        while (pending_events.size() > 0 || s_axis_tvalid || expected_beats.size() > 0)
            @(posedge i_clk);
        repeat (200) @(posedge i_clk);
    endtask

    task automatic run_random(input int count);
        repeat (count) pending_events = {pending_events, rand_event()};
        drain();
    endtask

    // Stimulus sequence
    initial begin
        i_rst_n     = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_data  = '0;
        foreach (pool_stat[i]) begin
            pool_stat[i] = sva_pkg::VS_FREE; pool_note[i] = 0; pool_layer[i] = 0;
            pool_grp[i] = 0; pool_loop[i] = 0; pool_age[i] = 0;
        end
        foreach (rr_layer[i]) rr_layer[i] = 0;
        age_now  = 0;
        poly_cap = 5'd16;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: corners, every kind, special cases
        write_cap(5'd2);
        add_event(sva_pkg::KIND_NOTE_ON, 4'd0, 7'd127, 8'd0, 3'd4, 4'hF, 1'b1, 4'd0);
        add_event(sva_pkg::KIND_NOTE_ON, 4'd15, 7'd1, 8'd255, 3'd7, 4'h8, 1'b0, 4'd15);
        add_event(sva_pkg::KIND_NOTE_ON, 4'd3, 7'd64, 8'd0, 3'd2, 4'hC, 1'b0, 4'd0);
        add_event(sva_pkg::KIND_NOTE_ON, 4'd3, 7'd64, 8'd0, 3'd0, 4'hF, 1'b0, 4'd0);
        add_event(sva_pkg::KIND_NOTE_ON, 4'd4, 7'd9, 8'd255, 3'd3, 4'h1, 1'b1, 4'd0);
        add_event(sva_pkg::KIND_NOTE_OFF, 4'd4, 7'd0, 8'd0, 3'd0, 4'h0, 1'b0, 4'd0);
        add_event(sva_pkg::KIND_NOTE_ON, 4'd0, 7'd0, 8'd0, 3'd1, 4'h1, 1'b0, 4'd0);
        add_event(sva_pkg::KIND_RECLAIM, 4'd0, 7'd0, 8'd0, 3'd0, 4'h0, 1'b0, 4'd0);
        add_event(sva_pkg::KIND_ENDED, 4'd0, 7'd0, 8'd0, 3'd0, 4'h0, 1'b0, 4'd1);
        add_event(sva_pkg::KIND_ENDED, 4'd0, 7'd0, 8'd0, 3'd0, 4'h0, 1'b0, 4'd15);
        add_event(3'd5, 4'd1, 7'd5, 8'd1, 3'd1, 4'h1, 1'b0, 4'd0);
        add_event(3'd7, 4'd1, 7'd5, 8'd1, 3'd1, 4'h1, 1'b0, 4'd0);
        add_event(sva_pkg::KIND_NOTE_ON, 4'd5, 7'd5, 8'd7, 3'd2, 4'h0, 1'b0, 4'd0);
        add_event(sva_pkg::KIND_ALL_OFF, 4'd0, 7'd0, 8'd0, 3'd0, 4'h0, 1'b0, 4'd0);
        drain();

        // random phases across polyphony settings, extremes included
        write_cap(5'd16);
        run_random(40);
        write_cap(5'd1);
        run_random(30);
        write_cap(5'd31);
        // let the sender run, then hold it back until every expected beat is in
        repeat (10) pending_events = {pending_events, rand_event()};
        repeat (30) @(posedge i_clk);
        hold_sender = 1'b1;
        while (s_axis_tvalid || expected_beats.size() > 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        hold_sender = 1'b0;
        drain();
        calm_phase = 1'b1;
        run_random(30);
        calm_phase = 1'b0;
        write_cap(5'd0);
        run_random(30);
        write_cap(5'($urandom_range(2, 8)));
        run_random(70);

        if (mismatches == 0)
            $display("sampler_voice_allocator_unit: match");
        else
            $display("sampler_voice_allocator_unit: mismatch");
        $finish;
    end

    // Timeout
    initial begin
        #2000000;
        $display("sampler_voice_allocator_unit: mismatch");
        $finish;
    end
endmodule

>>> sampler_voice_allocator_unit.f
src/sva_pkg.sv
src/sampler_voice_allocator_unit.sv
verif/tb_sampler_voice_allocator_unit.sv
